// ===== rtl/sdp_pkg.sv =====
package sdp_pkg;

  localparam int LENGTH_BITS   = 16;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_TLV_COUNT   = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_TEXT_BYTE_LIMIT = 1'b1;

  localparam logic [7:0]  MAX_TLV_RESET    = 8'd24;
  localparam logic [9:0]  TEXT_LIMIT_RESET = 10'd255;

  localparam logic [LENGTH_BITS-1:0] MIN_FRAME_BYTES = LENGTH_BITS'(12);

  localparam logic [7:0] OUI_BYTE0 = 8'h00;
  localparam logic [7:0] OUI_BYTE1 = 8'h00;
  localparam logic [7:0] OUI_BYTE2 = 8'h0C;
  localparam logic [7:0] PID_BYTE0 = 8'h20;
  localparam logic [7:0] PID_BYTE1 = 8'h00;

  localparam logic [15:0] TLV_DEVICE_ID   = 16'h0001;
  localparam logic [15:0] TLV_ADDRESSES   = 16'h0002;
  localparam logic [15:0] TLV_SW_VERSION  = 16'h0005;
  localparam logic [15:0] TLV_PLATFORM    = 16'h0006;
  localparam logic [15:0] TLV_VTP_DOMAIN  = 16'h0009;
  localparam logic [15:0] TLV_NATIVE_VLAN = 16'h000a;
  localparam logic [15:0] TLV_DUPLEX      = 16'h000b;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TLV_HDR,
    PH_TLV_VAL,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    RK_HEADER      = 3'd0,
    RK_TEXT        = 3'd1,
    RK_ADDR_COUNT  = 3'd2,
    RK_NATIVE_VLAN = 3'd3,
    RK_DUPLEX      = 3'd4,
    RK_FRAME_END   = 3'd5
  } result_kind_t;

  typedef enum logic [1:0] {
    TF_DEVICE_ID  = 2'd0,
    TF_SW_VERSION = 2'd1,
    TF_PLATFORM   = 2'd2,
    TF_VTP_DOMAIN = 2'd3
  } text_field_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic                   frame_start;
    logic [LENGTH_BITS-1:0] frame_length;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  text_field;
    logic [31:0] value;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic    data_valid;
    logic    end_valid;
    result_t data_res;
    result_t end_res;
  } step_res_t;

  typedef struct packed {
    logic [7:0] max_tlv_count;
    logic [9:0] text_byte_limit;
  } cfg_t;

endpackage

// ===== rtl/sdp_if.sv =====
interface sdp_in_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     data_byte;
  logic                           frame_start;
  logic [sdp_pkg::LENGTH_BITS-1:0] frame_length;

  modport source (output valid, output data_byte, output frame_start, output frame_length,
                  input ready);
  modport sink   (input valid, input data_byte, input frame_start, input frame_length,
                  output ready);
endinterface

interface sdp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [1:0]  text_field;
  logic [31:0] value;
  logic        last_of_run;

  modport source (output valid, output result_kind, output text_field, output value,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input text_field, input value,
                  input last_of_run, output ready);
endinterface

// ===== rtl/sdp_parse_core.sv =====
module sdp_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  sdp_pkg::item_t     item,
  input  sdp_pkg::cfg_t      cfg,
  output sdp_pkg::step_res_t res
);
  import sdp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] byte_position_r, byte_position_nxt;
  logic [LENGTH_BITS-1:0] frame_total_r, frame_total_nxt;
  logic [31:0]            header_word_r, header_word_nxt;
  logic [15:0]            current_type_r, current_type_nxt;
  logic [15:0]            current_length_r, current_length_nxt;
  logic [15:0]            value_bytes_left_r, value_bytes_left_nxt;
  logic [7:0]             tlvs_seen_r, tlvs_seen_nxt;
  logic [31:0]            value_acc_r, value_acc_nxt;
  logic [9:0]             text_emitted_r, text_emitted_nxt;
  logic                   text_stopped_r, text_stopped_nxt;

  // state as seen by this byte, after a frame start
  phase_t                 phase_e;
  logic [LENGTH_BITS-1:0] pos, tot;
  logic [31:0]            hdr_e, acc_e;
  logic [15:0]            type_e, len_e, vbl_e;
  logic [7:0]             tlvs_e;
  logic [9:0]             temit_e;
  logic                   tstop_e;

  logic [7:0]  b;
  logic        is_last, sig_bad, len_bad, far_end, stop_hdr, stop_other;
  logic        tf_valid, text_emit;
  logic [1:0]  tf_idx;
  logic [31:0] hdr_shift, acc_shift;
  logic [15:0] type_shift, len_shift, vlen, idx, vbl_dec;
  logic [7:0]  tlvs_inc;

  always_comb begin
    if (item.frame_start) begin
      tot     = item.frame_length;
      phase_e = (item.frame_length < MIN_FRAME_BYTES) ? PH_IDLE : PH_HEADER;
      pos     = '0;
      hdr_e   = '0;
      acc_e   = '0;
      type_e  = '0;
      len_e   = '0;
      vbl_e   = '0;
      tlvs_e  = '0;
      temit_e = '0;
      tstop_e = 1'b0;
    end else begin
      tot     = frame_total_r;
      phase_e = phase_r;
      pos     = byte_position_r;
      hdr_e   = header_word_r;
      acc_e   = value_acc_r;
      type_e  = current_type_r;
      len_e   = current_length_r;
      vbl_e   = value_bytes_left_r;
      tlvs_e  = tlvs_seen_r;
      temit_e = text_emitted_r;
      tstop_e = text_stopped_r;
    end
  end

  assign b          = item.data_byte;
  assign is_last    = ({1'b0, pos} + 17'd1) == {1'b0, tot};
  assign sig_bad    = (phase_e == PH_HEADER) &&
                      ((pos == LENGTH_BITS'(3) && b != OUI_BYTE0) ||
                       (pos == LENGTH_BITS'(4) && b != OUI_BYTE1) ||
                       (pos == LENGTH_BITS'(5) && b != OUI_BYTE2) ||
                       (pos == LENGTH_BITS'(6) && b != PID_BYTE0) ||
                       (pos == LENGTH_BITS'(7) && b != PID_BYTE1));
  assign hdr_shift  = {hdr_e[23:0], b};
  assign acc_shift  = {acc_e[23:0], b};
  assign type_shift = {type_e[7:0], b};
  assign len_shift  = {len_e[7:0], b};
  assign len_bad    = (len_shift < 16'd4) ||
                      ((18'(pos) - 18'd3 + 18'(len_shift)) > 18'(tot));
  assign tlvs_inc   = tlvs_e + 8'd1;
  assign far_end    = (18'(pos) + 18'd5) > 18'(tot);
  assign stop_hdr   = (tlvs_inc >= cfg.max_tlv_count) || far_end;
  assign stop_other = (tlvs_e >= cfg.max_tlv_count) || far_end;
  assign vlen       = len_e - 16'd4;
  assign idx        = vlen - vbl_e;
  assign vbl_dec    = vbl_e - 16'd1;

  always_comb begin
    case (type_e)
      TLV_DEVICE_ID:  begin tf_valid = 1'b1; tf_idx = TF_DEVICE_ID;  end
      TLV_SW_VERSION: begin tf_valid = 1'b1; tf_idx = TF_SW_VERSION; end
      TLV_PLATFORM:   begin tf_valid = 1'b1; tf_idx = TF_PLATFORM;   end
      TLV_VTP_DOMAIN: begin tf_valid = 1'b1; tf_idx = TF_VTP_DOMAIN; end
      default:        begin tf_valid = 1'b0; tf_idx = TF_DEVICE_ID;  end
    endcase
  end

  assign text_emit = tf_valid && !tstop_e && (b != 8'd0) && (temit_e < cfg.text_byte_limit);

  // next state
  always_comb begin
    phase_nxt            = phase_e;
    byte_position_nxt    = pos;
    frame_total_nxt      = tot;
    header_word_nxt      = hdr_e;
    current_type_nxt     = type_e;
    current_length_nxt   = len_e;
    value_bytes_left_nxt = vbl_e;
    tlvs_seen_nxt        = tlvs_e;
    value_acc_nxt        = acc_e;
    text_emitted_nxt     = temit_e;
    text_stopped_nxt     = tstop_e;
    unique case (phase_e)
      PH_HEADER: begin
        if (sig_bad) begin
          phase_nxt = PH_IDLE;
        end else begin
          if (pos >= LENGTH_BITS'(8)) header_word_nxt = hdr_shift;
          if (pos == LENGTH_BITS'(11)) begin
            if (stop_other) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt            = PH_TLV_HDR;
              value_bytes_left_nxt = '0;
              current_type_nxt     = '0;
              current_length_nxt   = '0;
            end
          end
        end
      end
      PH_TLV_HDR: begin
        if (vbl_e[1:0] < 2'd2) current_type_nxt = type_shift;
        else current_length_nxt = len_shift;
        if (vbl_e[1:0] != 2'd3) begin
          value_bytes_left_nxt = vbl_e + 16'd1;
        end else if (len_bad) begin
          phase_nxt = PH_SKIP;
        end else begin
          tlvs_seen_nxt        = tlvs_inc;
          value_bytes_left_nxt = len_shift - 16'd4;
          value_acc_nxt        = '0;
          text_emitted_nxt     = '0;
          text_stopped_nxt     = 1'b0;
          if (len_shift != 16'd4) begin
            phase_nxt = PH_TLV_VAL;
          end else if (stop_hdr) begin
            phase_nxt = PH_SKIP;
          end else begin
            value_bytes_left_nxt = '0;
            current_type_nxt     = '0;
            current_length_nxt   = '0;
          end
        end
      end
      PH_TLV_VAL: begin
        if (tf_valid) begin
          if (!tstop_e) begin
            if (text_emit) text_emitted_nxt = temit_e + 10'd1;
            else text_stopped_nxt = 1'b1;
          end
        end else if (type_e == TLV_ADDRESSES && len_e >= 16'd8) begin
          if (idx < 16'd4) value_acc_nxt = acc_shift;
        end else if (type_e == TLV_NATIVE_VLAN && len_e >= 16'd6) begin
          if (idx < 16'd2) value_acc_nxt = acc_shift;
        end
        value_bytes_left_nxt = vbl_dec;
        if (vbl_dec == 16'd0) begin
          if (stop_other) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt            = PH_TLV_HDR;
            value_bytes_left_nxt = '0;
            current_type_nxt     = '0;
            current_length_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
    if (phase_e != PH_IDLE && !sig_bad) begin
      if (is_last) phase_nxt = PH_IDLE;
      else byte_position_nxt = pos + LENGTH_BITS'(1);
    end
  end

  // results
  always_comb begin
    res.data_valid           = 1'b0;
    res.data_res.result_kind = RK_HEADER;
    res.data_res.text_field  = TF_DEVICE_ID;
    res.data_res.value       = '0;
    unique case (phase_e)
      PH_HEADER: begin
        if (!sig_bad && pos == LENGTH_BITS'(11)) begin
          res.data_valid     = 1'b1;
          res.data_res.value = hdr_shift;
        end
      end
      PH_TLV_VAL: begin
        if (tf_valid) begin
          if (text_emit) begin
            res.data_valid           = 1'b1;
            res.data_res.result_kind = RK_TEXT;
            res.data_res.text_field  = tf_idx;
            res.data_res.value       = {24'd0, b};
          end
        end else if (type_e == TLV_ADDRESSES && len_e >= 16'd8) begin
          if (idx == 16'd3) begin
            res.data_valid           = 1'b1;
            res.data_res.result_kind = RK_ADDR_COUNT;
            res.data_res.value       = acc_shift;
          end
        end else if (type_e == TLV_NATIVE_VLAN && len_e >= 16'd6) begin
          if (idx == 16'd1) begin
            res.data_valid           = 1'b1;
            res.data_res.result_kind = RK_NATIVE_VLAN;
            res.data_res.value       = {16'd0, acc_shift[15:0]};
          end
        end else if (type_e == TLV_DUPLEX && len_e >= 16'd5) begin
          if (idx == 16'd0) begin
            res.data_valid           = 1'b1;
            res.data_res.result_kind = RK_DUPLEX;
            res.data_res.value       = {31'd0, b != 8'd0};
          end
        end
      end
      default: ;
    endcase
    res.end_valid            = (phase_e != PH_IDLE) && !sig_bad && is_last;
    res.data_res.last_of_run = !res.end_valid;
    res.end_res.result_kind  = RK_FRAME_END;
    res.end_res.text_field   = TF_DEVICE_ID;
    res.end_res.value        = '0;
    res.end_res.last_of_run  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_IDLE;
      byte_position_r    <= '0;
      frame_total_r      <= '0;
      header_word_r      <= '0;
      current_type_r     <= '0;
      current_length_r   <= '0;
      value_bytes_left_r <= '0;
      tlvs_seen_r        <= '0;
      value_acc_r        <= '0;
      text_emitted_r     <= '0;
      text_stopped_r     <= 1'b0;
    end else if (step_en) begin
      phase_r            <= phase_nxt;
      byte_position_r    <= byte_position_nxt;
      frame_total_r      <= frame_total_nxt;
      header_word_r      <= header_word_nxt;
      current_type_r     <= current_type_nxt;
      current_length_r   <= current_length_nxt;
      value_bytes_left_r <= value_bytes_left_nxt;
      tlvs_seen_r        <= tlvs_seen_nxt;
      value_acc_r        <= value_acc_nxt;
      text_emitted_r     <= text_emitted_nxt;
      text_stopped_r     <= text_stopped_nxt;
    end
  end

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.end_valid) |=> (phase_r == PH_IDLE))
    else $error("frame end without return to idle");

  a_header_position: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.data_valid && res.data_res.result_kind == RK_HEADER) |=>
      (phase_r == PH_IDLE || byte_position_r == LENGTH_BITS'(12)))
    else $error("header result at wrong byte position");

  a_tlv_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TLV_HDR) |-> (value_bytes_left_r < 16'd4))
    else $error("tlv header byte count out of range");

endmodule

// ===== rtl/sdp_result_fifo.sv =====
module sdp_result_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  sdp_pkg::step_res_t res,
  output logic               room2,
  sdp_out_if.source          out_ch
);
  import sdp_pkg::*;

  localparam int DEPTH    = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  result_t               mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, end_ptr;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [1:0]            n_push;
  logic                  pop;

  assign n_push     = push_en ? (2'(res.data_valid) + 2'(res.end_valid)) : 2'd0;
  assign pop        = out_ch.valid && out_ch.ready;
  assign room2      = count_r <= CNT_BITS'(DEPTH - 2);
  assign end_ptr    = PTR_BITS'(wr_ptr_r + PTR_BITS'(res.data_valid));
  assign wr_ptr_nxt = PTR_BITS'(wr_ptr_r + PTR_BITS'(n_push));
  assign rd_ptr_nxt = PTR_BITS'(rd_ptr_r + PTR_BITS'(pop));
  assign count_nxt  = CNT_BITS'(count_r + CNT_BITS'(n_push) - CNT_BITS'(pop));

  assign out_ch.valid       = count_r != '0;
  assign out_ch.result_kind = mem_r[rd_ptr_r].result_kind;
  assign out_ch.text_field  = mem_r[rd_ptr_r].text_field;
  assign out_ch.value       = mem_r[rd_ptr_r].value;
  assign out_ch.last_of_run = mem_r[rd_ptr_r].last_of_run;

  always_ff @(posedge clk) begin
    if (push_en && res.data_valid) mem_r[wr_ptr_r] <= res.data_res;
    if (push_en && res.end_valid) mem_r[end_ptr] <= res.end_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> room2)
    else $error("push without room for two results");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push_en) |=> (count_r == CNT_BITS'($past(count_r) - 1'b1)))
    else $error("queue count not reduced on pop");

endmodule

// ===== rtl/snap_tlv_discovery_parser.sv =====
// Channel   Dir  Payload                                            Request done when
// in_ch     in   data_byte, frame_start, frame_length               valid && ready
// out_ch    out  result_kind, text_field, value, last_of_run        valid && ready
// cfg_*     in   cfg_addr (0 max_tlv_count, 1 text_byte_limit)      cfg_we
//
// One byte per cycle sustained while the queue has room; an accepted byte is registered, then parsed into the queue.
// A byte gives at most two results; the output drains one per cycle while out_ch.ready is high, from a 4-entry queue.
// Input stalls only while the queue holds more than two results.
// Synchronous active-low reset: idle phase, queue empty, registers at 24 and 255.
module snap_tlv_discovery_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  sdp_in_if.sink                            in_ch,
  sdp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [sdp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [sdp_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import sdp_pkg::*;

  item_t     item_r;
  logic      item_valid_r;
  cfg_t      cfg_r;
  step_res_t step_res;
  logic      room2, adv, accept;

  assign adv         = item_valid_r && room2;
  assign in_ch.ready = !item_valid_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte    <= in_ch.data_byte;
      item_r.frame_start  <= in_ch.frame_start;
      item_r.frame_length <= in_ch.frame_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_tlv_count   <= MAX_TLV_RESET;
      cfg_r.text_byte_limit <= TEXT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_TLV_COUNT:   cfg_r.max_tlv_count   <= cfg_wdata[7:0];
        CFG_TEXT_BYTE_LIMIT: cfg_r.text_byte_limit <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  sdp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  sdp_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (adv),
    .res     (step_res),
    .room2   (room2),
    .out_ch  (out_ch)
  );

endmodule
